FILE: design/proximity_obstacle_steering_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for proximity_obstacle_steering
// Concurrent checks on aclk, off while aresetn is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef PROXIMITY_OBSTACLE_STEERING_ASSERT_SVH
`define PROXIMITY_OBSTACLE_STEERING_ASSERT_SVH
`ifndef SYNTHESIS
// Check that the consequent holds in the same cycle as the antecedent.
`define POS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Check that the consequent holds in the cycle after the antecedent.
`define POS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define POS_ASSERT_IMPL(lbl, ante, cons, msg)
`define POS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: design/pos_pkg.sv
// ----------------------------------------------------------------------------
// pos_pkg
// Widths, register indexes and direction tables for obstacle steering.
// ----------------------------------------------------------------------------
package pos_pkg;

    localparam int NUM_SENSORS = 8;
    localparam int SENSOR_BITS = 13;
    localparam int TRIG_W      = 16;   // Q1.14 signed
    localparam int EXC_W       = 12;
    localparam int PROD_W      = 29;
    localparam int SUM_W       = 32;
    localparam int MAG_W       = 29;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int DEN_W       = SQ_W + 1;
    localparam int THR_W       = 12;
    localparam int SPD_W       = 10;
    localparam int SPD_SQ_W    = 2 * SPD_W;
    localparam int HALF_W      = SQ_W / 2;
    localparam int PART_W      = SPD_SQ_W + HALF_W;
    localparam int NUM_W       = SPD_SQ_W + SQ_W;
    localparam int QUO_W       = SPD_SQ_W;
    localparam int ROOT_W      = SPD_W;
    localparam int OUT_W       = 11;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 12;
    localparam int S_DATA_W    = NUM_SENSORS * SENSOR_BITS;
    localparam int M_DATA_W    = 24;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED = CFG_IDX_W'(1);

    localparam logic [THR_W-1:0] THRESHOLD_RESET    = THR_W'(30);
    localparam logic [SPD_W-1:0] CRUISE_SPEED_RESET = SPD_W'(500);

    localparam logic signed [TRIG_W-1:0] COS_Q14 [NUM_SENSORS] = '{
        16'sd15668, 16'sd10531, 16'sd0, -16'sd14189,
        -16'sd14189, 16'sd0, 16'sd10531, 16'sd15668
    };
    localparam logic signed [TRIG_W-1:0] SIN_Q14 [NUM_SENSORS] = '{
        16'sd4790, 16'sd12551, 16'sd16384, 16'sd8192,
        -16'sd8192, -16'sd16384, -16'sd12551, -16'sd4790
    };

    typedef struct packed {
        logic seen;
        logic vec_zero;
        logic x_neg;
        logic y_neg;
    } side_t;

endpackage

FILE: design/proximity_obstacle_steering.sv
// Pipeline: 8 front stages, 20 divider stages, 10 square-root stages and
// one output register, in that order.
// Throughput: one scan per cycle; every stage advances together while the
// output register is empty or being taken, so a stall holds the whole pipe.
// Reset (aresetn low, synchronous) clears all valid bits and loads
// threshold 30 and cruise speed 500.
// ----------------------------------------------------------------------------
// proximity_obstacle_steering
// Escape vector from eight proximity readings, then wheel speeds from
// speed*x/|v| via an exact pipelined division and integer square root.
// ----------------------------------------------------------------------------
`include "proximity_obstacle_steering_assert.svh"

module proximity_obstacle_steering import pos_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // prox_0 .. prox_7, 13 bits each
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // left_speed, right_speed, obstacle_seen, pad
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DIV_STEPS  = QUO_W;
    localparam int ROOT_STEPS = ROOT_W;

    logic                    adv;
    logic [THR_W-1:0]        threshold_reg;
    logic [SPD_W-1:0]        cruise_speed_reg;
    logic [SPD_SQ_W-1:0]     sq_speed_reg;

    // front stages
    logic                    v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic [EXC_W-1:0]        exc1_reg [NUM_SENSORS];
    logic [EXC_W-1:0]        exc1_next [NUM_SENSORS];
    logic [NUM_SENSORS-1:0]  hit1_reg, hit1_next;
    logic signed [PROD_W-1:0] px2_reg [NUM_SENSORS];
    logic signed [PROD_W-1:0] py2_reg [NUM_SENSORS];
    logic                    seen2_reg, seen3_reg, seen4_reg;
    logic signed [SUM_W-1:0] sx3_reg [NUM_SENSORS/2];
    logic signed [SUM_W-1:0] sy3_reg [NUM_SENSORS/2];
    logic signed [SUM_W-1:0] x4_reg, y4_reg;
    logic [MAG_W-1:0]        ax5_reg, ay5_reg;
    side_t                   side5_reg, side6_reg, side7_reg, side8_reg;
    logic [SQ_W-1:0]         x2_6_reg, y2_6_reg;
    logic [DEN_W-1:0]        den7_reg, den8_reg;
    logic [PART_W-1:0]       ahi7_reg, alo7_reg;
    logic [NUM_W-1:0]        num8_reg;

    // divider stages
    logic                    dv_reg   [DIV_STEPS];
    logic [DEN_W-1:0]        drem_reg [DIV_STEPS];
    logic [QUO_W-1:0]        dlow_reg [DIV_STEPS];
    logic [QUO_W-1:0]        dquo_reg [DIV_STEPS];
    logic [DEN_W-1:0]        dden_reg [DIV_STEPS];
    side_t                   dside_reg [DIV_STEPS];
    logic [DEN_W-1:0]        drem_next [DIV_STEPS];
    logic [QUO_W-1:0]        dlow_next [DIV_STEPS];
    logic [QUO_W-1:0]        dquo_next [DIV_STEPS];

    // square-root stages
    logic                    rv_reg    [ROOT_STEPS];
    logic [QUO_W-1:0]        rrad_reg  [ROOT_STEPS];
    logic [ROOT_W-1:0]       rroot_reg [ROOT_STEPS];
    side_t                   rside_reg [ROOT_STEPS];
    logic [ROOT_W-1:0]       rroot_next [ROOT_STEPS];

    logic                    m_tvalid_reg;
    logic [OUT_W-1:0]        left_reg, right_reg, left_next, right_next;
    logic                    seen_out_reg;

    assign adv       = !m_tvalid_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {1'b0, seen_out_reg, right_reg, left_reg};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg    <= THRESHOLD_RESET;
            cruise_speed_reg <= CRUISE_SPEED_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_THRESHOLD:    threshold_reg    <= cfg_data[THR_W-1:0];
                REG_CRUISE_SPEED: cruise_speed_reg <= cfg_data[SPD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        sq_speed_reg <= cruise_speed_reg * cruise_speed_reg;
    end

    // compare each reading to the threshold and take the excess
    always_comb begin
        logic signed [SENSOR_BITS-1:0] rd;
        logic signed [SENSOR_BITS-1:0] thr;
        logic signed [SENSOR_BITS-1:0] diff;
        thr = $signed({1'b0, threshold_reg});
        for (int i = 0; i < NUM_SENSORS; i++) begin
            rd           = $signed(s_tdata[i*SENSOR_BITS +: SENSOR_BITS]);
            diff         = rd - thr;
            hit1_next[i] = (rd >= thr);
            exc1_next[i] = hit1_next[i] ? diff[EXC_W-1:0] : '0;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0;
            v5_reg <= 1'b0; v6_reg <= 1'b0; v7_reg <= 1'b0; v8_reg <= 1'b0;
            for (int k = 0; k < DIV_STEPS; k++) dv_reg[k] <= 1'b0;
            for (int k = 0; k < ROOT_STEPS; k++) rv_reg[k] <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg; v3_reg <= v2_reg; v4_reg <= v3_reg;
            v5_reg <= v4_reg; v6_reg <= v5_reg; v7_reg <= v6_reg; v8_reg <= v7_reg;
            dv_reg[0] <= v8_reg;
            for (int k = 1; k < DIV_STEPS; k++) dv_reg[k] <= dv_reg[k-1];
            rv_reg[0] <= dv_reg[DIV_STEPS-1];
            for (int k = 1; k < ROOT_STEPS; k++) rv_reg[k] <= rv_reg[k-1];
            m_tvalid_reg <= rv_reg[ROOT_STEPS-1];
        end
    end

    // front stages: excess, products, two-level sum, magnitude, squares, scale
    always_ff @(posedge aclk) begin
        if (adv) begin
            hit1_reg <= hit1_next;
            for (int i = 0; i < NUM_SENSORS; i++) begin
                exc1_reg[i] <= exc1_next[i];
                px2_reg[i]  <= -(COS_Q14[i] * $signed({1'b0, exc1_reg[i]}));
                py2_reg[i]  <= SIN_Q14[i] * $signed({1'b0, exc1_reg[i]});
            end
            seen2_reg <= |hit1_reg;
            for (int i = 0; i < NUM_SENSORS/2; i++) begin
                sx3_reg[i] <= SUM_W'(px2_reg[2*i]) + SUM_W'(px2_reg[2*i+1]);
                sy3_reg[i] <= SUM_W'(py2_reg[2*i]) + SUM_W'(py2_reg[2*i+1]);
            end
            seen3_reg <= seen2_reg;
            x4_reg    <= sx3_reg[0] + sx3_reg[1] + sx3_reg[2] + sx3_reg[3];
            y4_reg    <= sy3_reg[0] + sy3_reg[1] + sy3_reg[2] + sy3_reg[3];
            seen4_reg <= seen3_reg;
            ax5_reg   <= x4_reg[SUM_W-1] ? MAG_W'(-x4_reg) : MAG_W'(x4_reg);
            ay5_reg   <= y4_reg[SUM_W-1] ? MAG_W'(-y4_reg) : MAG_W'(y4_reg);
            side5_reg <= '{seen: seen4_reg, vec_zero: (x4_reg == '0) && (y4_reg == '0),
                           x_neg: x4_reg[SUM_W-1], y_neg: y4_reg[SUM_W-1]};
            x2_6_reg  <= ax5_reg * ax5_reg;
            y2_6_reg  <= ay5_reg * ay5_reg;
            side6_reg <= side5_reg;
            den7_reg  <= DEN_W'(x2_6_reg) + DEN_W'(y2_6_reg);
            ahi7_reg  <= sq_speed_reg * x2_6_reg[SQ_W-1:HALF_W];
            alo7_reg  <= sq_speed_reg * x2_6_reg[HALF_W-1:0];
            side7_reg <= side6_reg;
            num8_reg  <= {ahi7_reg, HALF_W'(0)} + NUM_W'(alo7_reg);
            den8_reg  <= den7_reg;
            side8_reg <= side7_reg;
        end
    end

    // restoring division, one quotient bit per stage
    always_comb begin
        logic [DEN_W-1:0] rem_in;
        logic [QUO_W-1:0] low_in;
        logic [QUO_W-1:0] quo_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   trial;
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (k == 0) begin
                rem_in = DEN_W'(num8_reg[NUM_W-1:QUO_W]);
                low_in = num8_reg[QUO_W-1:0];
                quo_in = '0;
                den_in = den8_reg;
            end else begin
                rem_in = drem_reg[k-1];
                low_in = dlow_reg[k-1];
                quo_in = dquo_reg[k-1];
                den_in = dden_reg[k-1];
            end
            trial        = {rem_in, low_in[QUO_W-1]};
            dlow_next[k] = {low_in[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, den_in}) begin
                drem_next[k] = DEN_W'(trial - {1'b0, den_in});
                dquo_next[k] = {quo_in[QUO_W-2:0], 1'b1};
            end else begin
                drem_next[k] = trial[DEN_W-1:0];
                dquo_next[k] = {quo_in[QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                drem_reg[k] <= drem_next[k];
                dlow_reg[k] <= dlow_next[k];
                dquo_reg[k] <= dquo_next[k];
            end
            dden_reg[0]  <= den8_reg;
            dside_reg[0] <= side8_reg;
            for (int k = 1; k < DIV_STEPS; k++) begin
                dden_reg[k]  <= dden_reg[k-1];
                dside_reg[k] <= dside_reg[k-1];
            end
        end
    end

    // integer square root of the quotient, one root bit per stage
    always_comb begin
        logic [QUO_W-1:0]  rad_in;
        logic [ROOT_W-1:0] root_in;
        logic [ROOT_W-1:0] cand;
        logic [QUO_W-1:0]  cand_sq;
        for (int j = 0; j < ROOT_STEPS; j++) begin
            if (j == 0) begin
                rad_in  = dquo_reg[DIV_STEPS-1];
                root_in = '0;
            end else begin
                rad_in  = rrad_reg[j-1];
                root_in = rroot_reg[j-1];
            end
            cand          = root_in | (ROOT_W'(1) << (ROOT_W - 1 - j));
            cand_sq       = cand * cand;
            rroot_next[j] = (cand_sq <= rad_in) ? cand : root_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < ROOT_STEPS; j++) rroot_reg[j] <= rroot_next[j];
            rrad_reg[0]  <= dquo_reg[DIV_STEPS-1];
            rside_reg[0] <= dside_reg[DIV_STEPS-1];
            for (int j = 1; j < ROOT_STEPS; j++) begin
                rrad_reg[j]  <= rrad_reg[j-1];
                rside_reg[j] <= rside_reg[j-1];
            end
        end
    end

    // pick the wheel that turns and sign the steering speed
    always_comb begin
        side_t             sd;
        logic [OUT_W-1:0]  spd;
        logic [OUT_W-1:0]  mag;
        logic [OUT_W-1:0]  steer;
        sd    = rside_reg[ROOT_STEPS-1];
        spd   = {1'b0, cruise_speed_reg};
        mag   = {1'b0, rroot_reg[ROOT_STEPS-1]};
        steer = sd.x_neg ? OUT_W'(-mag) : mag;
        if (!sd.seen || sd.vec_zero) begin
            left_next  = spd;
            right_next = spd;
        end else if (!sd.y_neg) begin
            left_next  = steer;
            right_next = spd;
        end else begin
            left_next  = spd;
            right_next = steer;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            left_reg     <= left_next;
            right_reg    <= right_next;
            seen_out_reg <= rside_reg[ROOT_STEPS-1].seen;
        end
    end

    // a zero-length vector divides by zero, so its quotient is not bounded
    `POS_ASSERT_NEXT(a_enter, s_tvalid && s_tready, v1_reg, "accepted item lost at entry")
    `POS_ASSERT_IMPL(a_quo_bound,
        dv_reg[DIV_STEPS-1] && !dside_reg[DIV_STEPS-1].vec_zero,
        dquo_reg[DIV_STEPS-1] <= sq_speed_reg, "quotient above speed squared")
    `POS_ASSERT_IMPL(a_root, rv_reg[ROOT_STEPS-1],
        QUO_W'(rroot_reg[ROOT_STEPS-1] * rroot_reg[ROOT_STEPS-1]) <= rrad_reg[ROOT_STEPS-1],
        "root too large")
    `POS_ASSERT_IMPL(a_clear, m_tvalid && !m_tdata[2*OUT_W],
        m_tdata[OUT_W-1:0] == m_tdata[2*OUT_W-1:OUT_W], "wheels differ without obstacle")
    `POS_ASSERT_IMPL(a_one_cruise, m_tvalid,
        m_tdata[OUT_W-1:0] == {1'b0, cruise_speed_reg} ||
        m_tdata[2*OUT_W-1:OUT_W] == {1'b0, cruise_speed_reg},
        "neither wheel at cruise speed")

endmodule

FILE: verif/tb_proximity_obstacle_steering.sv
// ----------------------------------------------------------------------------
// Testbench for proximity_obstacle_steering
// Drives scans of eight proximity readings under several threshold and speed
// settings. Each wheel speed result is checked against an in-bench fixed
// point predictor. The scans come from a short directed table and then from
// random scans, with random idle cycles on both stream sides.
// ----------------------------------------------------------------------------
module tb_proximity_obstacle_steering;
    import pos_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(7);
    localparam int DRAIN_CYCLES = 45;
    localparam int STALL_LIMIT  = 4000;

    typedef logic [NUM_SENSORS-1:0][SENSOR_BITS-1:0] scan_t;

    typedef struct packed {
        logic [OUT_W-1:0] left_speed;
        logic [OUT_W-1:0] right_speed;
        logic             obstacle_seen;
    } wheels_t;

    typedef struct {
        scan_t   scan;
        bit      typed;
        wheels_t wheels;
    } scan_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // settings as the block should hold them
    int unsigned thr_now;
    int unsigned spd_now;

    wheels_t     wheels_due[$];
    int          errors;
    int          scans_sent;
    int          results_seen;
    int          obstacle_count;
    int          stall_cycles;
    bit          quiet_stretch;

    proximity_obstacle_steering u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Escape vector and wheel speeds for one scan at the current settings
    function automatic wheels_t steer_wheels(scan_t scan);
        longint             vx;
        longint             vy;
        longint             e;
        logic signed [SENSOR_BITS-1:0] rd;
        logic [127:0]       ax;
        logic [127:0]       ay;
        logic [127:0]       r2;
        logic [127:0]       lim;
        longint             q;
        longint             t;
        longint             spd;
        longint             steer;
        wheels_t            w;
        vx = 0;
        vy = 0;
        spd = spd_now;
        w.obstacle_seen = 1'b0;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            rd = scan[i];
            if (longint'(rd) >= longint'(thr_now)) begin
                e = longint'(rd) - longint'(thr_now);
                w.obstacle_seen = 1'b1;
                vx -= longint'(COS_Q14[i]) * e;
                vy += longint'(SIN_Q14[i]) * e;
            end
        end
        w.left_speed  = OUT_W'(spd);
        w.right_speed = OUT_W'(spd);
        if (w.obstacle_seen && (vx != 0 || vy != 0)) begin
            ax  = 128'(vx < 0 ? -vx : vx);
            ay  = 128'(vy < 0 ? -vy : vy);
            r2  = ax * ax + ay * ay;
            lim = ax * ax * 128'(spd) * 128'(spd);
            q = 0;
            // largest q with q^2 * |v|^2 <= speed^2 * x^2
            for (int b = 10; b >= 0; b--) begin
                t = q | (longint'(1) << b);
                if (t <= spd && r2 * 128'(t) * 128'(t) <= lim)
                    q = t;
            end
            steer = vx < 0 ? -q : q;
            if (vy >= 0)
                w.left_speed = OUT_W'(steer);
            else
                w.right_speed = OUT_W'(steer);
        end
        return w;
    endfunction

    // Result checker
    always @(posedge aclk) begin
        wheels_t got;
        wheels_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.left_speed    = m_tdata[OUT_W-1:0];
            got.right_speed   = m_tdata[2*OUT_W-1:OUT_W];
            got.obstacle_seen = m_tdata[2*OUT_W];
            results_seen++;
            if (wheels_due.size() == 0) begin
                $error("result with nothing expected: %h", m_tdata);
                errors++;
            end else begin
                want = wheels_due.pop_front();
                if (got.left_speed !== want.left_speed) begin
                    $error("left_speed expected %0d actual %0d",
                           $signed(want.left_speed), $signed(got.left_speed));
                    errors++;
                end
                if (got.right_speed !== want.right_speed) begin
                    $error("right_speed expected %0d actual %0d",
                           $signed(want.right_speed), $signed(got.right_speed));
                    errors++;
                end
                if (got.obstacle_seen !== want.obstacle_seen) begin
                    $error("obstacle_seen expected %0d actual %0d",
                           want.obstacle_seen, got.obstacle_seen);
                    errors++;
                end
            end
        end
    end

    // Stall the result side at random
    always @(negedge aclk) begin
        m_tready <= quiet_stretch ? 1'b1 : ($urandom_range(99) >= 29);
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_proximity_obstacle_steering: FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_THRESHOLD)
            thr_now = val & 12'hFFF;
        else if (idx == REG_CRUISE_SPEED)
            spd_now = val & 12'h3FF;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Send one scan; the expectation is recorded at the accepting edge.
    // Valid is left high so back-to-back scans need no extra assignment.
    task automatic send_scan(scan_t scan, bit typed, wheels_t typed_wheels);
        wheels_t w;
        @(negedge aclk);
        while (!quiet_stretch && $urandom_range(99) < 29) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= scan;
        do @(posedge aclk); while (!s_tready);
        w = typed ? typed_wheels : steer_wheels(scan);
        if (typed && w !== steer_wheels(scan)) begin
            $error("directed row disagrees with predictor for scan %h", scan);
            errors++;
        end
        wheels_due.push_back(w);
        scans_sent++;
        if (w.obstacle_seen)
            obstacle_count++;
    endtask

    // Wait for every result, then for the pipe to settle
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (wheels_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [SENSOR_BITS-1:0] random_reading();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            return SENSOR_BITS'($urandom);
        else if (pick < 80)
            return SENSOR_BITS'(int'(thr_now) + $urandom_range(600) - 200);
        else if (pick < 90)
            return SENSOR_BITS'(thr_now);
        else
            return SENSOR_BITS'(int'(thr_now) - 1);
    endfunction

    task automatic random_scans(int count);
        scan_t scan;
        wheels_t none;
        none = '0;
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
                // mostly few active sensors so steering turns both ways
                if ($urandom_range(2) == 0)
                    scan[i] = random_reading();
                else
                    scan[i] = SENSOR_BITS'(int'(thr_now) - 1 - $urandom_range(300));
            end
            send_scan(scan, 1'b0, none);
        end
    endtask

    function automatic scan_t fill_scan(logic [SENSOR_BITS-1:0] v);
        scan_t s;
        for (int i = 0; i < NUM_SENSORS; i++)
            s[i] = v;
        return s;
    endfunction

    function automatic wheels_t mk(int l, int r, bit seen);
        wheels_t w;
        w.left_speed    = OUT_W'(l);
        w.right_speed   = OUT_W'(r);
        w.obstacle_seen = seen;
        return w;
    endfunction

    initial begin
        scan_row_t rows[$];
        scan_row_t row;
        int unsigned thr_set[7];
        int unsigned spd_set[7];

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_THRESHOLD;
        cfg_data  = '0;
        errors = 0;
        scans_sent = 0;
        results_seen = 0;
        obstacle_count = 0;
        stall_cycles = 0;
        quiet_stretch = 1'b0;
        thr_now = THRESHOLD_RESET;
        spd_now = CRUISE_SPEED_RESET;

        // Directed scans at the reset settings (threshold 30, speed 500)
        row.typed = 1'b1;
        row.scan = fill_scan('0);               row.wheels = mk(500, 500, 0); rows.push_back(row);
        row.scan = fill_scan(13'h1000);         row.wheels = mk(500, 500, 0); rows.push_back(row);
        row.scan = fill_scan(13'd29);           row.wheels = mk(500, 500, 0); rows.push_back(row);
        // all at full scale: y cancels, x points back
        row.scan = fill_scan(13'd4095);         row.wheels = mk(-500, 500, 1); rows.push_back(row);
        // obstacle exactly at threshold gives a zero-length vector
        row.scan = fill_scan('0); row.scan[2] = 13'd30;
        row.wheels = mk(500, 500, 1); rows.push_back(row);
        row.scan = fill_scan('0); row.scan[2] = 13'd4095;
        row.wheels = mk(0, 500, 1); rows.push_back(row);
        row.scan = fill_scan('0); row.scan[5] = 13'd4095;
        row.wheels = mk(500, 0, 1); rows.push_back(row);
        row.typed = 1'b0;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            row.scan = fill_scan(13'h1000);
            row.scan[i] = 13'd4095;
            rows.push_back(row);
        end
        row.scan = '{13'h0AAA, 13'h1555, 13'h0AAA, 13'h1555,
                     13'h0AAA, 13'h1555, 13'h0AAA, 13'h1555};
        rows.push_back(row);
        row.scan = '{13'h1555, 13'h0AAA, 13'h1555, 13'h0AAA,
                     13'h1555, 13'h0AAA, 13'h1555, 13'h0AAA};
        rows.push_back(row);

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (rows[k])
            send_scan(rows[k].scan, rows[k].typed, rows[k].wheels);
        drain();

        // Settings per phase; extremes first, then fixed and random values, then back to reset
        thr_set = '{0, 4095, 100, $urandom_range(4095), $urandom_range(200), 2000, 30};
        spd_set = '{1023, 0, 1000, $urandom_range(1023), $urandom_range(1023), 1, 500};
        for (int ph = 0; ph < 7; ph++) begin
            write_reg(REG_THRESHOLD, CFG_DATA_W'(thr_set[ph]));
            if (ph == 0)
                write_reg(REG_CRUISE_SPEED, 12'hFFF);   // upper bits masked off
            else
                write_reg(REG_CRUISE_SPEED, CFG_DATA_W'(spd_set[ph]));
            // unmapped index must be ignored
            write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
            thr_now = thr_set[ph];
            spd_now = (ph == 0) ? 1023 : spd_set[ph];
            quiet_stretch = (ph == 2);
            random_scans(185);
            drain();
        end
        quiet_stretch = 1'b0;

        $display("Covered %0d scans (%0d with obstacles), %0d results, over eight settings",
                 scans_sent, obstacle_count, results_seen);
        $display("including threshold 0/4095 and cruise speed 0/1023 extremes");
        if (errors == 0)
            $display("tb_proximity_obstacle_steering: PASS");
        else
            $display("tb_proximity_obstacle_steering: FAIL");
        $finish;
    end

endmodule
